>>> hw/rtl/resizing_array_stack_defines.svh
// Assertion macros used by the checker file of the stack block.
`ifndef RESIZING_ARRAY_STACK_DEFINES_SVH
`define RESIZING_ARRAY_STACK_DEFINES_SVH

// Checks an implication on every rising edge of clock while reset is low.
`define RAS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition holds in every cycle outside reset.
`define RAS_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

`endif

>>> hw/rtl/ras_pkg.sv
`timescale 1ns / 1ps

package ras_pkg;

   // Default number of words in the physical store.
   localparam int RAS_DEPTH = 1024;

   // Fixed field widths.
   localparam int DATA_W    = 32;
   localparam int FUNC_W    = 2;
   localparam int CFG_W     = 11;
   localparam int CAP_OUT_W = 11;
   localparam int CSR_IDX_W = 1;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_INIT_CAP    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHRINK_LIMIT = 1'd1;

   // Reset values and the word returned by an empty pop or peek.
   localparam logic [CFG_W-1:0]  INIT_CAP_RESET     = 11'd10;
   localparam logic [CFG_W-1:0]  SHRINK_LIMIT_RESET = 11'd19;
   localparam logic [DATA_W-1:0] EMPTY_WORD         = 32'hFFFF_FF9D;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

endpackage

>>> hw/rtl/ras_ctrl.sv
`timescale 1ns / 1ps

module ras_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output ras_pkg::cmd_type  cmd
);
   import ras_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   // A new beat may enter while the previous result is on the output.
   assign accept = start && (state_ff != ST_EXEC);

   // Next state.
   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_RESP;
         ST_RESP: state_in = accept ? ST_EXEC : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands and handshake outputs.
   assign cmd.load  = accept;
   assign cmd.exec  = (state_ff == ST_EXEC);
   assign busy      = (state_ff == ST_EXEC);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

>>> hw/rtl/ras_datapath.sv
`timescale 1ns / 1ps

module ras_datapath #(
   parameter int DEPTH = ras_pkg::RAS_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ras_pkg::cmd_type                       cmd,
   input  logic [ras_pkg::FUNC_W-1:0]             req_func,
   input  logic signed [ras_pkg::DATA_W-1:0]      req_push_value,
   input  logic                                   csr_write_enable,
   input  logic [ras_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ras_pkg::CFG_W-1:0]              csr_write_data,
   output logic signed [ras_pkg::DATA_W-1:0]      rsp_data,
   output logic                                   rsp_was_empty,
   output logic                                   rsp_push_ok,
   output logic [ras_pkg::CAP_OUT_W-1:0]          rsp_capacity,
   output logic [ras_pkg::CAP_OUT_W-1:0]          rsp_peak_capacity,
   output logic [ras_pkg::DATA_W-1:0]             rsp_resize_count
);
   import ras_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int GROW_W = CNT_W + 3;

   // Latched request.
   logic [FUNC_W-1:0]  func_ff;
   logic [DATA_W-1:0]  value_ff;

   // Stack state.
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   cap_ff, cap_in;
   logic [CNT_W-1:0]   peak_ff, peak_in;
   logic [DATA_W-1:0]  resize_ff, resize_in;
   logic [CFG_W-1:0]   shrink_ff, shrink_in;

   // Result flags and read data.
   logic               empty_ff, empty_in;
   logic               read_ff, read_in;
   logic               ok_ff, ok_in;
   logic [DATA_W-1:0]  mem_q_ff;

   logic [DATA_W-1:0]  stack_mem [DEPTH];

   logic [GROW_W-1:0]  cap_x7;
   logic [GROW_W-1:0]  grown;
   logic [GROW_W-1:0]  grown_capped;
   logic [CNT_W-1:0]   grow_cap;
   logic               is_full;
   logic               can_grow;
   logic [CNT_W-1:0]   push_cap;
   logic               push_fits;
   logic               is_empty;
   logic [CNT_W-1:0]   count_dec;
   logic               do_shrink;
   logic [DATA_W-1:0]  resize_inc;
   logic [CMP_W-1:0]   csr_ext;
   logic [CMP_W-1:0]   init_clamped;
   logic [CNT_W-1:0]   init_cap;
   logic               init_write;
   logic               push_write;
   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   peak_ext;

   // Grow target: floor(cap * 7 / 4), capped at the store depth.
   assign cap_x7       = (GROW_W'(cap_ff) << 3) - GROW_W'(cap_ff);
   assign grown        = cap_x7 >> 2;
   assign grown_capped = (grown > GROW_W'(DEPTH)) ? GROW_W'(DEPTH) : grown;
   assign grow_cap     = grown_capped[CNT_W-1:0];
   assign is_full      = (count_ff >= cap_ff);
   assign can_grow     = (grow_cap > cap_ff);
   assign push_cap     = (is_full && can_grow) ? grow_cap : cap_ff;
   assign push_fits    = (count_ff < push_cap);

   // Pop side: shrink when the remaining count drops below half capacity and capacity exceeds the shrink limit.
   assign is_empty   = (count_ff == '0);
   assign count_dec  = count_ff - CNT_W'(1);
   assign do_shrink  = (count_dec < (cap_ff >> 1)) &&
                       (CMP_W'(cap_ff) > CMP_W'(shrink_ff));
   assign resize_inc = (resize_ff == '1) ? resize_ff : resize_ff + DATA_W'(1);

   // Capacity register write is clamped into one to depth.
   assign csr_ext      = CMP_W'(csr_write_data);
   assign init_clamped = (csr_ext == '0)            ? CMP_W'(1) :
                         (csr_ext > CMP_W'(DEPTH))  ? CMP_W'(DEPTH) : csr_ext;
   assign init_cap     = init_clamped[CNT_W-1:0];
   assign init_write   = csr_write_enable && (csr_index == REG_INIT_CAP);

   assign push_write = cmd.exec && (func_ff == FUNC_PUSH) && push_fits;

   // Next state of counters, capacity and result flags.
   always_comb begin
      count_in  = count_ff;
      cap_in    = cap_ff;
      peak_in   = peak_ff;
      resize_in = resize_ff;
      shrink_in = shrink_ff;
      empty_in  = empty_ff;
      read_in   = read_ff;
      ok_in     = ok_ff;
      if (csr_write_enable && (csr_index == REG_SHRINK_LIMIT)) begin
         shrink_in = csr_write_data;
      end
      if (init_write) begin
         count_in  = '0;
         cap_in    = init_cap;
         peak_in   = init_cap;
         resize_in = '0;
      end else if (cmd.exec) begin
         empty_in = 1'b0;
         read_in  = 1'b0;
         ok_in    = 1'b0;
         case (func_ff) inside
            FUNC_PUSH: begin
               if (is_full && can_grow) begin
                  cap_in    = grow_cap;
                  resize_in = resize_inc;
                  if (grow_cap > peak_ff) begin
                     peak_in = grow_cap;
                  end
               end
               if (push_fits) begin
                  count_in = count_ff + CNT_W'(1);
                  ok_in    = 1'b1;
               end
            end
            FUNC_POP, FUNC_PEEK: begin
               if (is_empty) begin
                  empty_in = 1'b1;
               end else begin
                  read_in = 1'b1;
                  if (func_ff == FUNC_POP) begin
                     count_in = count_dec;
                     if (do_shrink) begin
                        cap_in    = cap_ff >> 1;
                        resize_in = resize_inc;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         cap_ff    <= CNT_W'(INIT_CAP_RESET);
         peak_ff   <= CNT_W'(INIT_CAP_RESET);
         resize_ff <= '0;
         shrink_ff <= SHRINK_LIMIT_RESET;
         empty_ff  <= 1'b0;
         read_ff   <= 1'b0;
         ok_ff     <= 1'b0;
      end else begin
         count_ff  <= count_in;
         cap_ff    <= cap_in;
         peak_ff   <= peak_in;
         resize_ff <= resize_in;
         shrink_ff <= shrink_in;
         empty_ff  <= empty_in;
         read_ff   <= read_in;
         ok_ff     <= ok_in;
      end
   end

   // Request capture on an accepted beat.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         value_ff <= req_push_value;
      end
   end

   // Word store: a write above the top of stack and a registered read of the top.
   always_ff @(posedge clock) begin
      if (push_write) begin
         stack_mem[count_ff[ADDR_W-1:0]] <= value_ff;
      end
      if (cmd.exec) begin
         mem_q_ff <= stack_mem[count_dec[ADDR_W-1:0]];
      end
   end

   // Result fields; capacities are reported in eleven bits.
   assign cap_ext  = CMP_W'(cap_ff);
   assign peak_ext = CMP_W'(peak_ff);

   assign rsp_data          = empty_ff ? EMPTY_WORD : (read_ff ? mem_q_ff : '0);
   assign rsp_was_empty     = empty_ff;
   assign rsp_push_ok       = ok_ff;
   assign rsp_capacity      = cap_ext[CAP_OUT_W-1:0];
   assign rsp_peak_capacity = peak_ext[CAP_OUT_W-1:0];
   assign rsp_resize_count  = resize_ff;

endmodule

>>> hw/rtl/resizing_array_stack.sv
`timescale 1ns / 1ps

// Stack of signed 32-bit words with a logical capacity that grows and shrinks.
// Request channel: drive req_func (push, pop, peek) and req_push_value with
// start; the beat is taken at a rising edge where start is high and busy low.
// Result channel: rsp_valid is high for exactly one cycle with the result
// fields; the receiver cannot stall it and must take the beat in that cycle.
// Sequence: the cycle after the accepting edge is the execute cycle, the next
// one is the result cycle, and the result is taken at the rising edge that
// ends it. A new start is not taken in the execute cycle but is taken during
// the result cycle. The store's registered read port is addressed in the
// execute cycle.
// Configuration: csr_write_enable with csr_index and csr_write_data writes a
// register. Index 0 sets the initial capacity and empties the stack; index 1
// sets the shrink limit. Write only while no beat is pending.
// Reset (synchronous, active high): empty stack, capacity and peak 10,
// shrink limit 19, resize count zero. Store contents need no clearing.
module resizing_array_stack #(
   parameter int DEPTH = ras_pkg::RAS_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [ras_pkg::FUNC_W-1:0]             req_func,
   input  logic signed [ras_pkg::DATA_W-1:0]      req_push_value,
   output logic                                   rsp_valid,
   output logic signed [ras_pkg::DATA_W-1:0]      rsp_data,
   output logic                                   rsp_was_empty,
   output logic                                   rsp_push_ok,
   output logic [ras_pkg::CAP_OUT_W-1:0]          rsp_capacity,
   output logic [ras_pkg::CAP_OUT_W-1:0]          rsp_peak_capacity,
   output logic [ras_pkg::DATA_W-1:0]             rsp_resize_count,
   input  logic                                   csr_write_enable,
   input  logic [ras_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [ras_pkg::CFG_W-1:0]              csr_write_data
);
   import ras_pkg::*;

   cmd_type cmd;

   // Sequencer.
   ras_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // Store, counters and result registers.
   ras_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_func          (req_func),
      .req_push_value    (req_push_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_data          (rsp_data),
      .rsp_was_empty     (rsp_was_empty),
      .rsp_push_ok       (rsp_push_ok),
      .rsp_capacity      (rsp_capacity),
      .rsp_peak_capacity (rsp_peak_capacity),
      .rsp_resize_count  (rsp_resize_count)
   );

endmodule

>>> hw/rtl/ras_checker.sv
`timescale 1ns / 1ps
`include "resizing_array_stack_defines.svh"

module ras_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic signed [ras_pkg::DATA_W-1:0]   rsp_data,
   input logic                                rsp_was_empty,
   input logic                                rsp_push_ok
);
   import ras_pkg::*;

   // An accepted beat keeps the block busy for the execute cycle.
   `RAS_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")

   // Every execute cycle is followed by exactly one result beat.
   `RAS_ASSERT(a_busy_result, busy |=> (rsp_valid && !busy), "no result after execute cycle")

   // A result cannot be both an empty read and a stored push.
   `RAS_ALWAYS(a_flags_excl, !(rsp_valid && rsp_was_empty && rsp_push_ok), "conflicting flags")

   // An empty pop or peek returns the empty marker word.
   `RAS_ASSERT(a_empty_word, (rsp_valid && rsp_was_empty) |-> (rsp_data == EMPTY_WORD), "bad empty word")

endmodule

bind resizing_array_stack ras_checker u_ras_checker (.*);

>>> bench/resizing_array_stack_test.sv
`timescale 1ns / 1ps

module resizing_array_stack_test;
   import ras_pkg::*;

   // The operation code that the block must treat as a no-op.
   localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;
   localparam int QUIET_LIMIT = 5000;

   typedef enum logic {ENTRY_OP, ENTRY_CSR} entry_kind_type;

   // One pending stimulus entry: an operation beat or a register write.
   typedef struct {
      entry_kind_type            kind;
      logic [FUNC_W-1:0]         func;
      logic [DATA_W-1:0]         value;
      logic [CSR_IDX_W-1:0]      idx;
      logic [CFG_W-1:0]          data;
      int unsigned               idle_pct;
   } stack_entry_type;

   // The result fields that one operation produces.
   typedef struct packed {
      logic signed [DATA_W-1:0]  data;
      logic                      was_empty;
      logic                      push_ok;
      logic [CAP_OUT_W-1:0]      capacity;
      logic [CAP_OUT_W-1:0]      peak;
      logic [DATA_W-1:0]         resize_count;
   } stack_reply_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [FUNC_W-1:0]            req_func = FUNC_PUSH;
   logic signed [DATA_W-1:0]     req_push_value = '0;
   logic                         rsp_valid;
   logic signed [DATA_W-1:0]     rsp_data;
   logic                         rsp_was_empty;
   logic                         rsp_push_ok;
   logic [CAP_OUT_W-1:0]         rsp_capacity;
   logic [CAP_OUT_W-1:0]         rsp_peak_capacity;
   logic [DATA_W-1:0]            rsp_resize_count;
   logic                         csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]         csr_index = REG_INIT_CAP;
   logic [CFG_W-1:0]             csr_write_data = '0;

   // Shadow copy of the stack, its capacity bookkeeping and its registers.
   logic [DATA_W-1:0]            words [RAS_DEPTH];
   int unsigned                  depth_used;
   int unsigned                  cap_now;
   int unsigned                  cap_peak;
   logic [DATA_W-1:0]            resizes;
   logic [CFG_W-1:0]             cfg_init_cap;
   logic [CFG_W-1:0]             cfg_shrink;

   stack_entry_type              ops_to_send [$];
   stack_reply_type              replies_due [$];
   int unsigned                  sender_idle_pct;
   int unsigned                  mismatches;
   int unsigned                  ops_accepted;
   int unsigned                  csr_writes;
   int unsigned                  results_checked;
   int unsigned                  refused_pushes;
   int unsigned                  empty_reads;
   int unsigned                  widest_cap;
   int unsigned                  quiet_cycles;

   resizing_array_stack i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_push_value    (req_push_value),
      .rsp_valid         (rsp_valid),
      .rsp_data          (rsp_data),
      .rsp_was_empty     (rsp_was_empty),
      .rsp_push_ok       (rsp_push_ok),
      .rsp_capacity      (rsp_capacity),
      .rsp_peak_capacity (rsp_peak_capacity),
      .rsp_resize_count  (rsp_resize_count),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Empties the shadow stack and reloads capacity from the register.
   function automatic void restart_stack();
      cap_now = 32'(cfg_init_cap);
      if (cap_now < 1) cap_now = 1;
      if (cap_now > RAS_DEPTH) cap_now = RAS_DEPTH;
      cap_peak = cap_now;
      depth_used = 0;
      resizes = '0;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_INIT_CAP) begin
         cfg_init_cap = data;
         restart_stack();
      end else if (idx == REG_SHRINK_LIMIT) begin
         cfg_shrink = data;
      end
   endfunction

   function automatic void count_resize();
      if (resizes != '1) resizes++;
   endfunction

   // Applies one operation to the shadow stack and returns its result.
   function automatic stack_reply_type do_stack_op(logic [FUNC_W-1:0] func,
                                                   logic [DATA_W-1:0] value);
      stack_reply_type r;
      int unsigned     grown;
      r = '0;
      case (func) inside
         FUNC_PUSH: begin
            if (depth_used >= cap_now) begin
               grown = cap_now * 7 / 4;
               if (grown > RAS_DEPTH) grown = RAS_DEPTH;
               if (grown > cap_now) begin
                  cap_now = grown;
                  count_resize();
                  if (grown > cap_peak) cap_peak = grown;
               end
            end
            if (depth_used < cap_now && depth_used < RAS_DEPTH) begin
               words[depth_used] = value;
               depth_used++;
               r.push_ok = 1'b1;
            end else begin
               refused_pushes++;
            end
         end
         FUNC_POP, FUNC_PEEK: begin
            if (depth_used == 0) begin
               r.data = EMPTY_WORD;
               r.was_empty = 1'b1;
               empty_reads++;
            end else begin
               r.data = words[depth_used - 1];
               if (func == FUNC_POP) begin
                  depth_used--;
                  if (depth_used < cap_now / 2 && cap_now > 32'(cfg_shrink)) begin
                     cap_now = cap_now / 2;
                     count_resize();
                  end
               end
            end
         end
         default: ;
      endcase
      if (cap_now > widest_cap) widest_cap = cap_now;
      r.capacity = cap_now[CAP_OUT_W-1:0];
      r.peak = cap_peak[CAP_OUT_W-1:0];
      r.resize_count = resizes;
      return r;
   endfunction

   // Driver: presents queued beats and register writes, with random gaps.
   always @(posedge clock) begin : drive_p
      stack_entry_type head;
      logic            go;
      logic            we_n;
      if (reset) begin
         cfg_init_cap = INIT_CAP_RESET;
         cfg_shrink = SHRINK_LIMIT_RESET;
         restart_stack();
         start <= 1'b0;
         csr_write_enable <= 1'b0;
      end else begin
         go = start;
         we_n = 1'b0;
         if (csr_write_enable) begin
            apply_csr(csr_index, csr_write_data);
            csr_writes++;
         end
         if (start && !busy) begin
            replies_due.push_back(do_stack_op(req_func, req_push_value));
            ops_accepted++;
            go = 1'b0;
         end
         if (!go && ops_to_send.size() > 0) begin
            head = ops_to_send[0];
            if (head.kind == ENTRY_CSR) begin
               // Registers change only once every result has come back.
               if (replies_due.size() == 0 && !rsp_valid) begin
                  void'(ops_to_send.pop_front());
                  we_n = 1'b1;
                  csr_index <= head.idx;
                  csr_write_data <= head.data;
               end
            end else if ($urandom_range(99) >= head.idle_pct) begin
               void'(ops_to_send.pop_front());
               go = 1'b1;
               req_func <= head.func;
               req_push_value <= head.value;
            end
         end
         start <= go;
         csr_write_enable <= we_n;
      end
   end

   function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endfunction

   // Monitor: every result beat is matched against the oldest prediction.
   always @(posedge clock) begin : watch_p
      stack_reply_type want;
      if (!reset && rsp_valid) begin
         if (replies_due.size() == 0) begin
            $error("result beat arrived with no operation outstanding");
            mismatches++;
         end else begin
            want = replies_due.pop_front();
            check_field("rsp_data", want.data, rsp_data);
            check_field("rsp_was_empty", DATA_W'(want.was_empty),
                        DATA_W'(rsp_was_empty));
            check_field("rsp_push_ok", DATA_W'(want.push_ok), DATA_W'(rsp_push_ok));
            check_field("rsp_capacity", DATA_W'(want.capacity), DATA_W'(rsp_capacity));
            check_field("rsp_peak_capacity", DATA_W'(want.peak),
                        DATA_W'(rsp_peak_capacity));
            check_field("rsp_resize_count", want.resize_count, rsp_resize_count);
            results_checked++;
         end
      end
   end

   // Watchdog on cycles in which no beat or write is taken.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_op(logic [FUNC_W-1:0] func, logic [DATA_W-1:0] value);
      stack_entry_type e;
      e = '{kind: ENTRY_OP, func: func, value: value, idx: '0, data: '0,
            idle_pct: sender_idle_pct};
      ops_to_send.push_back(e);
   endtask

   task automatic add_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      stack_entry_type e;
      e = '{kind: ENTRY_CSR, func: FUNC_PUSH, value: '0, idx: idx, data: data,
            idle_pct: 0};
      ops_to_send.push_back(e);
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Mostly small capacities so that grow and shrink happen often.
   function automatic logic [CFG_W-1:0] pick_capacity();
      case ($urandom_range(19))
         0, 1: return '0;
         2, 3: return 11'd1;
         4: return CFG_W'(RAS_DEPTH);
         5: return '1;
         6: return CFG_W'($urandom_range(2047));
         default: return CFG_W'($urandom_range(40, 2));
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_shrink();
      case ($urandom_range(9))
         0, 1: return '0;
         2: return '1;
         3: return CFG_W'($urandom_range(2047));
         default: return CFG_W'($urandom_range(30));
      endcase
   endfunction

   // Register writes, then push bursts followed by pop bursts, with some loose noise.
   task automatic add_random_segment(int unsigned n_ops);
      int unsigned made;
      int unsigned k;
      made = 0;
      add_csr(REG_SHRINK_LIMIT, pick_shrink());
      add_csr(REG_INIT_CAP, pick_capacity());
      while (made < n_ops) begin
         if ($urandom_range(99) < 80) begin
            k = $urandom_range(24, 1);
            repeat (k) add_op(($urandom_range(9) == 0) ? FUNC_PEEK : FUNC_PUSH, pick_word());
            made += k;
            k = $urandom_range(k + 2, 1);
            repeat (k) add_op(($urandom_range(5) == 0) ? FUNC_PEEK : FUNC_POP, pick_word());
            made += k;
         end else begin
            k = $urandom_range(6, 1);
            repeat (k) add_op(FUNC_W'($urandom_range(3)), pick_word());
            made += k;
         end
      end
   endtask

   // Stimulus and end of run.
   initial begin
      int unsigned pct [3];
      pct = '{23, 81, 0};
      sender_idle_pct = pct[0];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Empty reads, extreme words, the reserved code, then drain to empty.
      add_op(FUNC_POP, 32'h0);
      add_op(FUNC_PEEK, 32'hFFFF_FFFF);
      add_op(FUNC_RESERVED, 32'hFFFF_FFFF);
      add_op(FUNC_PUSH, 32'h7FFF_FFFF);
      add_op(FUNC_PUSH, 32'h8000_0000);
      add_op(FUNC_PUSH, 32'hFFFF_FFFF);
      add_op(FUNC_PEEK, 32'h0);
      add_op(FUNC_RESERVED, 32'h0);
      repeat (4) add_op(FUNC_POP, 32'h5A5A_5A5A);
      // Capacity one cannot grow, so the second push is refused.
      add_csr(REG_INIT_CAP, 11'd1);
      add_op(FUNC_PUSH, 32'h1234_5678);
      add_op(FUNC_PUSH, 32'hDEAD_BEEF);
      add_op(FUNC_POP, 32'h0);
      // Grow from three to five, then shrink twice with no shrink limit.
      add_csr(REG_SHRINK_LIMIT, 11'd0);
      add_csr(REG_INIT_CAP, 11'd3);
      repeat (5) add_op(FUNC_PUSH, pick_word());
      repeat (6) add_op(FUNC_POP, 32'h0);
      // Out-of-range capacity values are clamped.
      add_csr(REG_INIT_CAP, 11'd0);
      add_op(FUNC_PUSH, 32'h0);
      add_csr(REG_INIT_CAP, 11'd2047);
      add_op(FUNC_PEEK, 32'h0);

      // Random traffic under three sender gap settings.
      foreach (pct[p]) begin
         sender_idle_pct = pct[p];
         repeat (3) add_random_segment(50);
      end

      while (ops_to_send.size() != 0 || start || csr_write_enable) @(posedge clock);
      while (replies_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Drove %0d stack operations and %0d register writes; %0d results checked.",
               ops_accepted, csr_writes, results_checked);
      $display("Refused pushes: %0d, empty reads: %0d, largest capacity reached: %0d.",
               refused_pushes, empty_reads, widest_cap);
      if (mismatches == 0 && replies_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
